// File: rtl/cbd_pkg.sv
// Shared types and constants of the cross blur with decay block.
package cbd_pkg;

    localparam int MAX_WIDTH_DEFAULT = 2048;

    localparam int PIXEL_W = 8;
    localparam int FRAME_WIDTH_W = 12;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int ROW_W = 12;

    localparam int MIN_WIDTH = 32;
    localparam int MIN_HEIGHT = 3;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [FRAME_WIDTH_W-1:0] FRAME_WIDTH_RESET = 12'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic [PIXEL_W-1:0] blurred;
        logic               frame_done;
    } result_t;

endpackage

// File: rtl/cbd_if.sv
// Valid/ready channel interfaces for pixels, results and configuration writes.
interface cbd_pix_if;
    logic                        valid;
    logic                        ready;
    logic [cbd_pkg::PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface cbd_res_if;
    logic                        valid;
    logic                        ready;
    logic [cbd_pkg::PIXEL_W-1:0] blurred;
    logic                        frame_done;

    modport source (output valid, output blurred, output frame_done, input ready);
    modport sink (input valid, input blurred, input frame_done, output ready);
endinterface

interface cbd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cbd_pkg::CFG_INDEX_W-1:0] index;
    logic [cbd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/cross_blur_with_decay.sv
// Top level of the cross blur with decay block.
//
// Takes one pixel per cycle in raster order while the result queue is not full and,
// from the second row on, gives one result per pixel: the four-neighbour average of
// the pixel one row above, less one and floored at zero, or zero on the border; the
// result for the last pixel of a frame carries frame_done. The rate is set by the
// single write port and single read port of each line buffer, which reads two
// columns ahead so that the pixel one row above and its right neighbour are already
// registered when the pixel arrives. Results pass through a two-entry queue, so
// pixels keep flowing while one result waits. Writing either register restarts the
// frame at row 0 and keeps the line buffers; the buffers need no clearing.
module cross_blur_with_decay
#(
    parameter int MAX_WIDTH = cbd_pkg::MAX_WIDTH_DEFAULT
)
(
    input logic        clk,
    input logic        rst_n,
    cbd_pix_if.sink    pixels,
    cbd_res_if.source  results,
    cbd_cfg_if.sink    cfg
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int AW = WW + 1;
    localparam int PW = cbd_pkg::PIXEL_W;
    localparam int HW = cbd_pkg::FRAME_HEIGHT_W;
    localparam int RW = cbd_pkg::ROW_W;

    logic [cbd_pkg::FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [cbd_pkg::FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [CW-1:0]                      col_reg;
    logic [CW-1:0]                      col_next;
    logic [RW-1:0]                      row_reg;
    logic [RW-1:0]                      row_next;
    logic [PW-1:0]                      left_reg;

    // Line buffers and the read-ahead pipeline: ahead holds column x+1, cur column x
    logic [PW-1:0] older_mem [MAX_WIDTH];
    logic [PW-1:0] newer_mem [MAX_WIDTH];
    logic [PW-1:0] ahead_up_reg;
    logic [PW-1:0] ahead_mid_reg;
    logic [PW-1:0] cur_up_reg;
    logic [PW-1:0] cur_mid_reg;

    logic [WW-1:0]     width_use;
    logic [HW-1:0]     height_use;
    logic              accept;
    logic              cfg_write;
    logic              cfg_hit;
    logic              last_col;
    logic              last_row;
    logic              emit;
    logic              border;
    logic [PW+1:0]     sum;
    logic [PW-1:0]     avg;
    logic [AW-1:0]     ahead_col;
    logic [CW-1:0]     ahead_addr;
    logic              fifo_full;
    cbd_pkg::result_t  result;
    cbd_pkg::result_t  fifo_data;

    always_comb
    begin
        if (frame_width_reg < cbd_pkg::FRAME_WIDTH_W'(cbd_pkg::MIN_WIDTH))
        begin
            width_use = WW'(cbd_pkg::MIN_WIDTH);
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            width_use = WW'(MAX_WIDTH);
        end
        else
        begin
            width_use = WW'(frame_width_reg);
        end

        if (frame_height_reg < HW'(cbd_pkg::MIN_HEIGHT))
        begin
            height_use = HW'(cbd_pkg::MIN_HEIGHT);
        end
        else if (frame_height_reg > HW'(cbd_pkg::MAX_HEIGHT))
        begin
            height_use = HW'(cbd_pkg::MAX_HEIGHT);
        end
        else
        begin
            height_use = frame_height_reg;
        end
    end

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;
    assign cfg_hit = cfg_write && ((cfg.index == cbd_pkg::REG_FRAME_WIDTH) ||
                                   (cfg.index == cbd_pkg::REG_FRAME_HEIGHT));

    assign pixels.ready = !fifo_full;
    assign accept = pixels.valid && pixels.ready;

    assign last_col = ((WW'(col_reg) + WW'(1)) == width_use);
    assign last_row = ((HW'(row_reg) + HW'(1)) == height_use);
    assign emit = (row_reg != RW'(0));
    assign border = (row_reg == RW'(1)) || (col_reg == CW'(0)) || last_col;

    assign sum = (PW+2)'(cur_up_reg) + (PW+2)'(pixels.pixel) +
                 (PW+2)'(left_reg) + (PW+2)'(ahead_mid_reg);
    assign avg = sum[PW+1:2];

    always_comb
    begin
        if (border)
        begin
            result.blurred = '0;
        end
        else if (avg == '0)
        begin
            result.blurred = '0;
        end
        else
        begin
            result.blurred = avg - PW'(1);
        end
        result.frame_done = last_col && last_row;
    end

    // Column two ahead of the current one, wrapping into the next row
    always_comb
    begin
        ahead_col = AW'(col_reg) + AW'(2);
        if (ahead_col >= AW'(width_use))
        begin
            ahead_col = ahead_col - AW'(width_use);
        end
        ahead_addr = ahead_col[CW-1:0];
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? RW'(0) : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= cbd_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= cbd_pkg::FRAME_HEIGHT_RESET;
            col_reg <= '0;
            row_reg <= '0;
            left_reg <= '0;
        end
        else
        begin
            if (cfg_write && (cfg.index == cbd_pkg::REG_FRAME_WIDTH))
            begin
                frame_width_reg <= cfg.data[cbd_pkg::FRAME_WIDTH_W-1:0];
            end
            if (cfg_write && (cfg.index == cbd_pkg::REG_FRAME_HEIGHT))
            begin
                frame_height_reg <= cfg.data[cbd_pkg::FRAME_HEIGHT_W-1:0];
            end
            // A register write restarts the frame
            if (cfg_hit)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
            begin
                left_reg <= cur_mid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            older_mem[col_reg] <= cur_mid_reg;
            newer_mem[col_reg] <= pixels.pixel;
            ahead_up_reg <= older_mem[ahead_addr];
            ahead_mid_reg <= newer_mem[ahead_addr];
            cur_up_reg <= ahead_up_reg;
            cur_mid_reg <= ahead_mid_reg;
        end
    end

    cbd_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && emit),
        .push_data (result),
        .full      (fifo_full),
        .out_valid (results.valid),
        .out_data  (fifo_data),
        .out_ready (results.ready)
    );

    assign results.blurred = fifo_data.blurred;
    assign results.frame_done = fifo_data.frame_done;

endmodule

// File: rtl/cbd_out_fifo.sv
// Two-entry result queue that decouples the pixel side from the result side.
module cbd_out_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cbd_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    output cbd_pkg::result_t out_data,
    input  logic             out_ready
);

    cbd_pkg::result_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             pop;

    assign full = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data = slot_reg[rd_ptr_reg];
    assign pop = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: tb/cross_blur_with_decay_tb.sv
// Self-checking testbench of the cross blur with decay block: directed frames, then random traffic.
module cross_blur_with_decay_tb;

    localparam int LINE_LEN = cbd_pkg::MAX_WIDTH_DEFAULT;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PER_PHASE = 40;

    // Indexes that hold no register
    localparam logic [cbd_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [cbd_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum int {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_t;
    typedef enum int {SHADE_UNIFORM, SHADE_DARK, SHADE_BRIGHT, SHADE_EXTREME} shade_t;

    typedef struct packed {
        logic [cbd_pkg::CFG_INDEX_W-1:0] index;
        logic [cbd_pkg::CFG_DATA_W-1:0]  data;
    } reg_write_t;

    logic clk = 1'b0;
    logic rst_n;

    cbd_pix_if pix_ch();
    cbd_res_if res_ch();
    cbd_cfg_if cfg_ch();

    cross_blur_with_decay #(.MAX_WIDTH(LINE_LEN)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .pixels(pix_ch),
        .results(res_ch),
        .cfg(cfg_ch)
    );

    // Predicted state of the block
    logic [cbd_pkg::FRAME_WIDTH_W-1:0]  width_reg = cbd_pkg::FRAME_WIDTH_RESET;
    logic [cbd_pkg::FRAME_HEIGHT_W-1:0] height_reg = cbd_pkg::FRAME_HEIGHT_RESET;
    bit [cbd_pkg::PIXEL_W-1:0]          row_two_up [LINE_LEN];
    bit [cbd_pkg::PIXEL_W-1:0]          row_one_up [LINE_LEN];
    int unsigned                        col_pos;
    int unsigned                        row_pos;
    bit [15:0]                          prev_centres;

    logic [cbd_pkg::PIXEL_W-1:0] pixel_queue[$];
    reg_write_t                  reg_write_queue[$];
    cbd_pkg::result_t            blur_expected[$];

    int  px_pushed;
    int  px_taken_count;
    int  res_predicted;
    int  res_checked;
    int  writes_pushed;
    int  writes_taken;
    int  idle_cycles;
    int  send_gap_pct;
    int  sink_stall_pct;
    bit  pix_taken;
    bit  write_taken;
    bit  mismatch_seen;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned active_width();
        if (width_reg < cbd_pkg::MIN_WIDTH)
            return cbd_pkg::MIN_WIDTH;
        if (width_reg > LINE_LEN)
            return LINE_LEN;
        return width_reg;
    endfunction

    function automatic int unsigned active_height();
        if (height_reg < cbd_pkg::MIN_HEIGHT)
            return cbd_pkg::MIN_HEIGHT;
        if (height_reg > cbd_pkg::MAX_HEIGHT)
            return cbd_pkg::MAX_HEIGHT;
        return height_reg;
    endfunction

    // Advance the predicted raster position by one pixel; returns 1 when a result is due.
    function automatic bit blur_predict(input logic [cbd_pkg::PIXEL_W-1:0] pix,
                                        output cbd_pkg::result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned up;
        int unsigned centre;
        int unsigned right;
        int unsigned avg;
        w = active_width();
        h = active_height();
        x = (col_pos >= w) ? w - 1 : col_pos;
        y = (row_pos >= h) ? h - 1 : row_pos;
        up = row_two_up[x];
        centre = row_one_up[x];
        right = (x + 1 < w) ? row_one_up[x + 1] : 0;
        res.blurred = '0;
        res.frame_done = (x == w - 1) && (y == h - 1);
        // second row of the frame and first or last column are border
        if (y >= 2 && x != 0 && x != w - 1)
        begin
            avg = (up + pix + prev_centres[7:0] + right) / 4;
            res.blurred = (avg == 0) ? '0 : cbd_pkg::PIXEL_W'(avg - 1);
        end
        row_two_up[x] = centre[cbd_pkg::PIXEL_W-1:0];
        row_one_up[x] = pix;
        prev_centres = {prev_centres[7:0], centre[7:0]};
        if (x + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : y + 1;
        end
        else
        begin
            col_pos = x + 1;
            row_pos = y;
        end
        return y != 0;
    endfunction

    function automatic void push_pixel(input logic [cbd_pkg::PIXEL_W-1:0] value);
        pixel_queue.push_back(value);
        px_pushed++;
    endfunction

    task automatic send_pixels(input int unsigned count, input shade_t shade);
        logic [cbd_pkg::PIXEL_W-1:0] value;
        for (int unsigned i = 0; i < count; i++)
        begin
            case (shade)
                SHADE_DARK:
                begin
                    value = cbd_pkg::PIXEL_W'($urandom_range(0, 7));
                end
                SHADE_BRIGHT:
                begin
                    value = cbd_pkg::PIXEL_W'($urandom_range(240, 255));
                end
                SHADE_EXTREME:
                begin
                    value = $urandom_range(1) ? 8'hFF : 8'h00;
                end
                default:
                begin
                    value = cbd_pkg::PIXEL_W'($urandom);
                end
            endcase
            push_pixel(value);
        end
    endtask

    // Write only once every pixel is in and every result is out, after a settling pause.
    task automatic write_reg(input logic [cbd_pkg::CFG_INDEX_W-1:0] index,
                             input logic [cbd_pkg::CFG_DATA_W-1:0] data);
        reg_write_t wr;
        wait (px_taken_count == px_pushed && res_checked == res_predicted);
        repeat (SETTLE_CYCLES) @(posedge clk);
        wr.index = index;
        wr.data = data;
        reg_write_queue.push_back(wr);
        writes_pushed++;
        wait (writes_taken == writes_pushed);
    endtask

    // Pixel driver: hold the item until its transaction completes
    always @(negedge clk)
    begin
        if (!rst_n)
            pix_ch.valid <= 1'b0;
        else if (!pix_ch.valid || pix_taken)
        begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                pix_ch.valid <= 1'b1;
                pix_ch.pixel <= pixel_queue.pop_front();
            end
            else
                pix_ch.valid <= 1'b0;
        end
    end

    // Register write driver
    always @(negedge clk)
    begin
        if (!rst_n)
            cfg_ch.valid <= 1'b0;
        else if (!cfg_ch.valid || write_taken)
        begin
            if (reg_write_queue.size() != 0)
            begin
                cfg_ch.valid <= 1'b1;
                {cfg_ch.index, cfg_ch.data} <= reg_write_queue.pop_front();
            end
            else
                cfg_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
        res_ch.ready <= $urandom_range(99) >= sink_stall_pct;

    always @(posedge clk)
    begin : observe
        cbd_pkg::result_t predicted;
        pix_taken = rst_n && pix_ch.valid && pix_ch.ready;
        write_taken = rst_n && cfg_ch.valid && cfg_ch.ready;
        if (write_taken)
        begin
            // any real register restarts the frame; the line buffers stay
            case (cfg_ch.index)
                cbd_pkg::REG_FRAME_WIDTH:
                begin
                    width_reg = cfg_ch.data[cbd_pkg::FRAME_WIDTH_W-1:0];
                    col_pos = 0;
                    row_pos = 0;
                end
                cbd_pkg::REG_FRAME_HEIGHT:
                begin
                    height_reg = cfg_ch.data;
                    col_pos = 0;
                    row_pos = 0;
                end
                default:
                begin
                end
            endcase
            writes_taken++;
        end
        if (pix_taken)
        begin
            if (blur_predict(pix_ch.pixel, predicted))
            begin
                blur_expected.push_back(predicted);
                res_predicted++;
            end
            px_taken_count++;
        end
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (blur_expected.size() == 0)
            begin
                mismatch_seen = 1'b1;
                $error("result with none expected: blurred %0d, frame_done %0b",
                       res_ch.blurred, res_ch.frame_done);
            end
            else
            begin
                predicted = blur_expected.pop_front();
                if (res_ch.blurred !== predicted.blurred)
                begin
                    mismatch_seen = 1'b1;
                    $error("blurred: expected %0d, got %0d",
                           predicted.blurred, res_ch.blurred);
                end
                if (res_ch.frame_done !== predicted.frame_done)
                begin
                    mismatch_seen = 1'b1;
                    $error("frame_done: expected %0b, got %0b",
                           predicted.frame_done, res_ch.frame_done);
                end
                res_checked++;
            end
        end
    end

    // Watchdog: count cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((pix_ch.valid && pix_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
            || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("** cross_blur_with_decay: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int unsigned pick;
        int unsigned wdata;
        int unsigned hdata;
        int unsigned frame_len;
        int unsigned batch;
        int unsigned phase_items;
        bit          aligned;

        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = cbd_pkg::REG_FRAME_WIDTH;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        send_gap_pct = 0;
        sink_stall_pct = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset width keeps row 0 open, so none of these gives a result
        send_pixels(32, SHADE_UNIFORM);

        // Top data bit is dropped, so the width reads 0 and clamps to the minimum
        write_reg(cbd_pkg::REG_FRAME_WIDTH, 13'h1000);
        write_reg(cbd_pkg::REG_FRAME_HEIGHT, 13'd5);
        // Row bands: full scale, a cut to black, then ones to hit the decay floor
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 32; c++)
                push_pixel((r < 2) ? 8'd255 : (r < 3) ? 8'd0 : 8'd1);

        // Height clamps to the minimum; writes to unused indexes mid-frame must not restart it
        write_reg(cbd_pkg::REG_FRAME_HEIGHT, 13'd0);
        send_pixels(40, SHADE_EXTREME);
        write_reg(REG_SPARE_A, 13'h1FFF);
        write_reg(REG_SPARE_B, 13'h0555);
        send_pixels(active_width() * active_height() - 40, SHADE_EXTREME);

        // Oversized width clamps to the line length and height to the maximum, so row 0 stays open
        write_reg(cbd_pkg::REG_FRAME_WIDTH, 13'h0FFF);
        write_reg(cbd_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
        send_pixels(32, SHADE_BRIGHT);
        write_reg(cbd_pkg::REG_FRAME_WIDTH, 13'd32);
        write_reg(cbd_pkg::REG_FRAME_HEIGHT, 13'd4096);
        send_pixels(2 * 32 + 1, SHADE_DARK);

        for (int ph = FLOW_FREE; ph <= FLOW_BOTH; ph++)
        begin
            case (flow_t'(ph))
                FLOW_SRC_GAPS:
                begin
                    send_gap_pct = 60;
                    sink_stall_pct = 0;
                end
                FLOW_SINK_STALLS:
                begin
                    send_gap_pct = 0;
                    sink_stall_pct = 60;
                end
                FLOW_BOTH:
                begin
                    send_gap_pct = 34;
                    sink_stall_pct = 34;
                end
                default:
                begin
                    send_gap_pct = 0;
                    sink_stall_pct = 0;
                end
            endcase
            phase_items = 0;
            while (phase_items < RANDOM_PER_PHASE)
            begin
                aligned = 1'b0;
                if ($urandom_range(3) != 0)
                begin
                    pick = $urandom_range(99);
                    if (pick < 70)
                        wdata = 32;
                    else if (pick < 85)
                        wdata = $urandom_range(33, 48);
                    else
                        wdata = $urandom_range(0, 31);
                    pick = $urandom_range(99);
                    if (pick < 70)
                        hdata = $urandom_range(3, 4);
                    else if (pick < 90)
                        hdata = $urandom_range(0, 2);
                    else
                        hdata = 5;
                    pick = $urandom_range(2);
                    if (pick != 1)
                        write_reg(cbd_pkg::REG_FRAME_WIDTH, cbd_pkg::CFG_DATA_W'(wdata));
                    if (pick != 0)
                        write_reg(cbd_pkg::REG_FRAME_HEIGHT, cbd_pkg::CFG_DATA_W'(hdata));
                    aligned = 1'b1;
                end
                frame_len = active_width() * active_height();
                // mostly whole frames; otherwise cut the frame short or run across its end
                if (aligned && $urandom_range(9) < 7)
                    batch = frame_len;
                else
                    batch = $urandom_range(1, frame_len);
                send_pixels(batch, shade_t'($urandom_range(SHADE_EXTREME)));
                phase_items += batch;
            end
        end

        wait (px_taken_count == px_pushed && res_checked == res_predicted);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (!mismatch_seen && blur_expected.size() == 0)
            $display("** cross_blur_with_decay: PASSED **");
        else
            $display("** cross_blur_with_decay: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
rtl/cbd_pkg.sv
rtl/cbd_if.sv
rtl/cbd_out_fifo.sv
rtl/cross_blur_with_decay.sv
tb/cross_blur_with_decay_tb.sv
